### rtl/sample_in_ball_challenge_defines.svh
// ---------------------------------------------------------------------------
// Sample-in-ball challenge: assertion macros
// Concurrent checks shared by the sampler RTL, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef SAMPLE_IN_BALL_CHALLENGE_DEFINES_SVH
`define SAMPLE_IN_BALL_CHALLENGE_DEFINES_SVH

// Same-cycle implication.
`define SIBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SIBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sibc_pkg.sv
// ---------------------------------------------------------------------------
// Sample-in-ball challenge package
// Sizes, codes and the beat formats passed between the sampler stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sibc_pkg;

    localparam int N_COEFFS    = 1024;
    localparam int IDX_W       = $clog2(N_COEFFS);
    localparam int POS_W       = IDX_W + 1;

    // coefficient store: rows of ROW_W bits
    localparam int ROW_W       = 32;
    localparam int ROW_BITS    = $clog2(ROW_W);
    localparam int ROWS        = N_COEFFS / ROW_W;
    localparam int ROW_IDX_W   = IDX_W - ROW_BITS;

    localparam int FUNC_W      = 2;
    localparam int WORD_W      = 16;
    localparam int RIDX_W      = 10;
    localparam int PPOS_W      = 10;
    localparam int LIMIT_W     = 17;
    localparam int TAU_W       = 11;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 1;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    localparam int LIMIT_RESET = 65536;
    localparam int TAU_RESET   = 64;
    localparam int TAU_RESET_SAT = (TAU_RESET > N_COEFFS) ? N_COEFFS : TAU_RESET;

    typedef enum logic [FUNC_W-1:0] {
        FN_START = 2'd0,
        FN_CAND  = 2'd1,
        FN_READ  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REJECT_LIMIT = 1'b0,
        REG_TAU          = 1'b1
    } t_cfg_reg;

    // decided item handed from the front stage to the store stage
    typedef struct packed {
        t_func            func;
        logic             accepted;
        logic [IDX_W-1:0] sel_idx;   // reduced candidate, or read index
        logic [IDX_W-1:0] pos_idx;   // counter before the advance
        logic             done;
    } t_cmd;

    typedef struct packed {
        logic              read_bit;
        logic              done_res;
        logic [PPOS_W-1:0] placed_pos;
        logic              accepted;
    } t_result;

endpackage

`default_nettype wire

### rtl/sibc_front.sv
// ---------------------------------------------------------------------------
// Sample-in-ball front stage
// Input register, configuration, position counter and the accept decision.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sample_in_ball_challenge_defines.svh"

module sibc_front
    import sibc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                  i_in_vld,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [WORD_W-1:0]     i_word,
    input  wire logic [RIDX_W-1:0]     i_ridx,
    output logic                       o_in_rdy,
    input  wire logic                  i_b_rdy,
    output logic                       o_a_fire,
    output t_cmd                       o_cmd
);

    localparam int TAU_CMP_W = (TAU_W > POS_W) ? TAU_W : POS_W;

    logic                r_a_vld;
    t_func               r_a_func;
    logic [WORD_W-1:0]   r_a_word;
    logic [RIDX_W-1:0]   r_a_ridx;
    logic [LIMIT_W-1:0]  r_limit;
    logic [TAU_W-1:0]    r_tau;
    logic [POS_W-1:0]    r_pos;
    logic                r_finished;

    logic                n_a_vld;
    logic [POS_W-1:0]    n_pos;
    logic                n_finished;

    logic                w_in_fire;
    logic [IDX_W-1:0]    w_red;
    logic                w_in_limit;
    logic                w_pos_ok;
    logic                w_acc;
    logic [POS_W-1:0]    w_tau_sat;
    logic [POS_W-1:0]    w_pos_inc;

    assign o_in_rdy  = !r_a_vld || i_b_rdy;
    assign w_in_fire = i_in_vld && o_in_rdy;
    assign o_a_fire  = r_a_vld && i_b_rdy;

    // size is a power of two: the reduction keeps the low bits
    assign w_red      = IDX_W'(r_a_word % WORD_W'(N_COEFFS));
    assign w_in_limit = ({1'b0, r_a_word} < r_limit);
    assign w_pos_ok   = ({1'b0, w_red} <= r_pos) && (r_pos < POS_W'(N_COEFFS));
    assign w_acc      = (r_a_func == FN_CAND) && !r_finished && w_in_limit && w_pos_ok;
    assign w_pos_inc  = r_pos + 1'b1;

    assign w_tau_sat = (TAU_CMP_W'(r_tau) > TAU_CMP_W'(N_COEFFS)) ? POS_W'(N_COEFFS)
                                                                  : POS_W'(r_tau);

    always_comb begin
        n_pos      = r_pos;
        n_finished = r_finished;
        case (r_a_func)
            FN_START: begin
                n_pos      = POS_W'(N_COEFFS) - w_tau_sat;
                n_finished = (w_tau_sat == '0);
            end
            FN_CAND: begin
                if (w_acc) begin
                    n_pos      = w_pos_inc;
                    n_finished = (w_pos_inc >= POS_W'(N_COEFFS));
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_a_vld = r_a_vld;
        if (w_in_fire) begin
            n_a_vld = 1'b1;
        end else if (o_a_fire) begin
            n_a_vld = 1'b0;
        end
    end

    always_comb begin
        o_cmd.func     = r_a_func;
        o_cmd.accepted = w_acc;
        o_cmd.sel_idx  = (r_a_func == FN_READ) ? IDX_W'(r_a_ridx) : w_red;
        o_cmd.pos_idx  = r_pos[IDX_W-1:0];
        o_cmd.done     = n_finished;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_limit    <= LIMIT_W'(LIMIT_RESET);
            r_tau      <= TAU_W'(TAU_RESET);
            r_pos      <= POS_W'(N_COEFFS) - POS_W'(TAU_RESET_SAT);
            r_finished <= 1'b1;
        end else begin
            r_a_vld <= n_a_vld;
            if (o_a_fire) begin
                r_pos      <= n_pos;
                r_finished <= n_finished;
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_REJECT_LIMIT: r_limit <= i_cfg_wdata[LIMIT_W-1:0];
                    REG_TAU:          r_tau   <= i_cfg_wdata[TAU_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // hold the beat while the next stage is full
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_a_func <= t_func'(i_func);
            r_a_word <= i_word;
            r_a_ridx <= i_ridx;
        end
    end

    `SIBC_ASSERT_NEXT(a_pos_advance, i_clk, i_rst_n, o_a_fire && w_acc,
        r_pos == $past(w_pos_inc), "counter did not advance on an accepted candidate")
    `SIBC_ASSERT_NOW(a_no_acc_finished, i_clk, i_rst_n, r_finished,
        !w_acc, "candidate accepted after the run finished")
    `SIBC_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1,
        r_pos <= POS_W'(N_COEFFS), "position counter beyond the coefficient count")

endmodule

`default_nettype wire

### rtl/sibc_store.sv
// ---------------------------------------------------------------------------
// Sample-in-ball coefficient store
// Row memory with two read ports, row valid flags and the swap update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sample_in_ball_challenge_defines.svh"

module sibc_store
    import sibc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_a_fire,
    input  wire t_cmd    i_cmd,
    output logic         o_b_rdy,
    output logic         o_res_vld,
    output t_result      o_res,
    input  wire logic    i_out_rdy
);

    logic [ROW_W-1:0]     r_mem [ROWS];
    logic [ROW_W-1:0]     r_rd_sel;
    logic [ROW_W-1:0]     r_rd_pos;
    logic                 r_b_vld;
    t_cmd                 r_b_cmd;
    logic [ROWS-1:0]      r_rowvld;
    logic                 r_fw_vld;
    logic [ROW_IDX_W-1:0] r_fw_row;
    logic [ROW_W-1:0]     r_fw_data;

    logic                 n_b_vld;
    logic [ROWS-1:0]      n_rowvld;

    logic                 w_b_fire;
    logic [ROW_IDX_W-1:0] w_a_sel_row;
    logic [ROW_IDX_W-1:0] w_a_pos_row;
    logic [ROW_IDX_W-1:0] w_sel_row;
    logic [ROW_IDX_W-1:0] w_pos_row;
    logic [ROW_BITS-1:0]  w_sel_col;
    logic [ROW_BITS-1:0]  w_pos_col;
    logic [ROW_W-1:0]     w_row_sel;
    logic [ROW_W-1:0]     w_row_pos;
    logic                 w_sel_bit;
    logic                 w_wr_en;
    logic [ROW_IDX_W-1:0] w_wr_row;
    logic [ROW_W-1:0]     w_wr_data;

    // latest row contents: last write wins, an invalid row reads as zero
    function automatic logic [ROW_W-1:0] f_resolve(
        input logic [ROW_IDX_W-1:0] row,
        input logic [ROW_W-1:0]     raw,
        input logic                 fw_vld,
        input logic [ROW_IDX_W-1:0] fw_row,
        input logic [ROW_W-1:0]     fw_data,
        input logic [ROWS-1:0]      rowvld
    );
        logic [ROW_W-1:0] data;
        if (fw_vld && (fw_row == row)) begin
            data = fw_data;
        end else if (rowvld[row]) begin
            data = raw;
        end else begin
            data = '0;
        end
        return data;
    endfunction

    assign o_b_rdy   = !r_b_vld || i_out_rdy;
    assign w_b_fire  = r_b_vld && i_out_rdy;
    assign o_res_vld = r_b_vld;

    assign w_a_sel_row = i_cmd.sel_idx[IDX_W-1:ROW_BITS];
    assign w_a_pos_row = i_cmd.pos_idx[IDX_W-1:ROW_BITS];
    assign w_sel_row   = r_b_cmd.sel_idx[IDX_W-1:ROW_BITS];
    assign w_pos_row   = r_b_cmd.pos_idx[IDX_W-1:ROW_BITS];
    assign w_sel_col   = r_b_cmd.sel_idx[ROW_BITS-1:0];
    assign w_pos_col   = r_b_cmd.pos_idx[ROW_BITS-1:0];

    assign w_row_sel = f_resolve(w_sel_row, r_rd_sel, r_fw_vld, r_fw_row, r_fw_data, r_rowvld);
    assign w_row_pos = f_resolve(w_pos_row, r_rd_pos, r_fw_vld, r_fw_row, r_fw_data, r_rowvld);
    assign w_sel_bit = w_row_sel[w_sel_col];

    // The swap flips exactly one zero to one: the counter slot if the
    // reduced slot already holds a one, otherwise the reduced slot.
    assign w_wr_en = w_b_fire && r_b_cmd.accepted;
    always_comb begin
        if (w_sel_bit) begin
            w_wr_row  = w_pos_row;
            w_wr_data = w_row_pos | (ROW_W'(1) << w_pos_col);
        end else begin
            w_wr_row  = w_sel_row;
            w_wr_data = w_row_sel | (ROW_W'(1) << w_sel_col);
        end
    end

    always_comb begin
        o_res.accepted   = r_b_cmd.accepted;
        o_res.placed_pos = r_b_cmd.accepted ? PPOS_W'(r_b_cmd.sel_idx) : '0;
        o_res.done_res   = r_b_cmd.done;
        o_res.read_bit   = (r_b_cmd.func == FN_READ) ? w_sel_bit : 1'b0;
    end

    always_comb begin
        n_b_vld = r_b_vld;
        if (i_a_fire) begin
            n_b_vld = 1'b1;
        end else if (w_b_fire) begin
            n_b_vld = 1'b0;
        end
    end

    always_comb begin
        n_rowvld = r_rowvld;
        if (w_b_fire && (r_b_cmd.func == FN_START)) begin
            n_rowvld = '0;
        end else if (w_wr_en) begin
            n_rowvld[w_wr_row] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_a_fire) begin
            r_rd_sel <= r_mem[w_a_sel_row];
            r_rd_pos <= r_mem[w_a_pos_row];
        end
        if (w_wr_en) begin
            r_mem[w_wr_row] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld  <= 1'b0;
            r_rowvld <= '0;
            r_fw_vld <= 1'b0;
        end else begin
            r_b_vld  <= n_b_vld;
            r_rowvld <= n_rowvld;
            if (w_b_fire && (r_b_cmd.func == FN_START)) begin
                r_fw_vld <= 1'b0;
            end else if (w_wr_en) begin
                r_fw_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_a_fire) begin
            r_b_cmd <= i_cmd;
        end
        if (w_wr_en) begin
            r_fw_row  <= w_wr_row;
            r_fw_data <= w_wr_data;
        end
    end

    `SIBC_ASSERT_NOW(a_fw_row_valid, i_clk, i_rst_n, r_fw_vld,
        r_rowvld[r_fw_row], "forwarded row not marked valid")
    `SIBC_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, w_b_fire && (r_b_cmd.func == FN_START),
        !r_fw_vld && (r_rowvld == '0), "start did not clear the store")

endmodule

`default_nettype wire

### rtl/sample_in_ball_challenge.sv
// ---------------------------------------------------------------------------
// Sample-in-ball challenge sampler
// Builds a sparse 1024-coefficient 0/1 challenge by an inside-out shuffle.
// Every input beat gives one result beat; a new beat is taken every cycle
// while the output is not stalled, passing the front register, the store
// read and the output register. The 1024 coefficients sit in a 32 x 32-bit
// row memory with two registered read ports (reduced slot and counter slot)
// and one write port; per-row valid flags cleared by a start beat stand in
// for clearing the memory, so there is no clearing pass after reset or
// start. Write the configuration registers only while no beat is in flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_in_ball_challenge
    import sibc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,    // 0 reject_limit, 1 tau
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata, // sample_word[15:0], read_index[25:16]
    input  wire logic [FUNC_W-1:0]      s_axis_tuser, // func[1:0]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata  // accepted[0], placed_pos[10:1],
                                                      // done_res[11], read_bit[12]
);

    logic     w_b_rdy;
    logic     w_a_fire;
    t_cmd     w_cmd;
    logic     w_res_vld;
    t_result  w_res;
    logic     w_out_rdy;

    logic     r_out_vld;
    t_result  r_out;

    sibc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_vld    (s_axis_tvalid),
        .i_func      (s_axis_tuser),
        .i_word      (s_axis_tdata[WORD_W-1:0]),
        .i_ridx      (s_axis_tdata[WORD_W +: RIDX_W]),
        .o_in_rdy    (s_axis_tready),
        .i_b_rdy     (w_b_rdy),
        .o_a_fire    (w_a_fire),
        .o_cmd       (w_cmd)
    );

    sibc_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_a_fire  (w_a_fire),
        .i_cmd     (w_cmd),
        .o_b_rdy   (w_b_rdy),
        .o_res_vld (w_res_vld),
        .o_res     (w_res),
        .i_out_rdy (w_out_rdy)
    );

    assign w_out_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_vld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

endmodule

`default_nettype wire
